// File: hdl/sic_pkg.sv
// Shared types, codes and defaults for the scalar integer core.
package sic_pkg;

  localparam int XLEN          = 32;
  localparam int PC_W          = 26;
  localparam int REG_IDX_W     = 5;
  localparam int IMM_W         = 16;
  localparam int MEM_WORDS_DEF = 1024;
  localparam int REG_COUNT_DEF = 32;

  typedef enum logic [3:0] {
    MODE_ADDI = 4'd0,
    MODE_SUBI = 4'd1,
    MODE_LW   = 4'd2,
    MODE_SW   = 4'd3,
    MODE_BEQ  = 4'd4,
    MODE_BNE  = 4'd5,
    MODE_BGT  = 4'd6,
    MODE_BLT  = 4'd7,
    MODE_J    = 4'd8,
    MODE_MOV  = 4'd9,
    MODE_LI   = 4'd10,
    MODE_ADD  = 4'd11,
    MODE_SUB  = 4'd12,
    MODE_MUL  = 4'd13,
    MODE_DIV  = 4'd14,
    MODE_HALT = 4'd15
  } mode_t;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_ADDR = 2'd1,
    FAULT_DIV0 = 2'd2
  } fault_t;

  typedef struct packed {
    mode_t                        mode;
    logic [REG_IDX_W-1:0]         dest_reg;
    logic [REG_IDX_W-1:0]         src_reg_a;
    logic [REG_IDX_W-1:0]         src_reg_b;
    logic signed [IMM_W-1:0]      immediate;
    logic [PC_W-1:0]              jump_target;
  } in_t;

  typedef struct packed {
    logic [PC_W-1:0]              next_pc;
    logic signed [XLEN-1:0]       write_value;
    logic                         halted;
    fault_t                       fault;
  } out_t;

  // Request and response of the multiply/divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } mdu_req_t;

  typedef struct packed {
    logic            done;
    logic [XLEN-1:0] result;
  } mdu_rsp_t;

endpackage

// File: hdl/sic_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module sic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/sic_alu.sv
// Shared 33-bit signed adder/subtractor for arithmetic, addresses and compares.
module sic_alu (
  input  logic [sic_pkg::XLEN-1:0] x,
  input  logic [sic_pkg::XLEN-1:0] y,
  input  logic                     sub,
  output logic [sic_pkg::XLEN:0]   res
);

  logic [sic_pkg::XLEN:0] xe;
  logic [sic_pkg::XLEN:0] ye;

  // Sign-extend by one bit so the sum never overflows.
  assign xe  = {x[sic_pkg::XLEN-1], x};
  assign ye  = {y[sic_pkg::XLEN-1], y};
  assign res = sub ? (xe - ye) : (xe + ye);

endmodule

// File: hdl/sic_mdu.sv
// Iterative multiply and signed divide unit, one bit per cycle.
module sic_mdu (
  input  logic                     clk,
  input  logic                     rst_n,
  input  sic_pkg::mdu_req_t        req,
  input  logic [sic_pkg::XLEN-1:0] opa,
  input  logic [sic_pkg::XLEN-1:0] opb,
  output sic_pkg::mdu_rsp_t        rsp
);

  localparam int XL  = sic_pkg::XLEN;
  localparam int CW  = $clog2(XL);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          div_r, div_nxt;
  logic          neg_r, neg_nxt;
  logic [XL-1:0] acc_r, acc_nxt;
  logic [XL-1:0] x_r, x_nxt;
  logic [XL-1:0] y_r, y_nxt;
  logic [XL-1:0] rem_sh;
  logic [XL:0]   diff;

  // For division acc holds the remainder, x the divisor and y the
  // dividend shifting out while quotient bits shift in.
  assign rem_sh = {acc_r[XL-2:0], y_r[XL-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, x_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    neg_nxt  = neg_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(XL - 1);
      div_nxt  = req.is_div;
      acc_nxt  = '0;
      if (req.is_div) begin
        neg_nxt = opa[XL-1] ^ opb[XL-1];
        x_nxt   = opb[XL-1] ? (~opb + XL'(1)) : opb;
        y_nxt   = opa[XL-1] ? (~opa + XL'(1)) : opa;
      end else begin
        neg_nxt = 1'b0;
        x_nxt   = opa;
        y_nxt   = opb;
      end
    end else if (busy_r) begin
      if (div_r) begin
        if (!diff[XL]) begin
          acc_nxt = diff[XL-1:0];
          y_nxt   = {y_r[XL-2:0], 1'b1};
        end else begin
          acc_nxt = rem_sh;
          y_nxt   = {y_r[XL-2:0], 1'b0};
        end
      end else begin
        if (y_r[0]) begin
          acc_nxt = acc_r + x_r;
        end
        x_nxt = {x_r[XL-2:0], 1'b0};
        y_nxt = {1'b0, y_r[XL-1:1]};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = div_r ? (neg_r ? (~y_r + XL'(1)) : y_r) : acc_r;

endmodule

// File: hdl/scalar_integer_core_step.sv
// Top level of the scalar integer core: sequencer, register file and data memory.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-------------------------------
//  in_     | in        | in_valid / in_ready | sic_pkg::in_t (one instruction)
//  out_    | out       | out_valid/out_ready | sic_pkg::out_t (one result)
//
// A request passes S_RB, S_RD, S_EXEC and S_OUT from acceptance until the next
// can be taken; a load in range adds S_LOAD, and multiply and nonzero divide
// wait in S_MDU for the bit-serial multiply/divide unit. A result reaches the
// output register in the cycle before the next request can be taken. A halted
// core sends each request straight to S_OUT. The sequence is set by the single
// read port of the register file, read three times per executed request.
// After reset the data memory is cleared one word per cycle, all MEM_WORDS
// words in turn, and no request is taken meanwhile. A stalled result sits
// in the output register while the next request is already accepted.
module scalar_integer_core_step #(
  parameter int MEM_WORDS = sic_pkg::MEM_WORDS_DEF,
  parameter int REG_COUNT = sic_pkg::REG_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sic_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sic_pkg::out_t out_data
);

  localparam int XL   = sic_pkg::XLEN;
  localparam int PW   = sic_pkg::PC_W;
  localparam int IW   = sic_pkg::REG_IDX_W;
  localparam int RA_W = $clog2(REG_COUNT);
  localparam int MA_W = $clog2(MEM_WORDS);
  localparam logic [XL:0] MEM_LIM = (XL + 1)'(MEM_WORDS);

  // One-hot sequencer states.
  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_RB    = 8'b0000_0100,
    S_RD    = 8'b0000_1000,
    S_EXEC  = 8'b0001_0000,
    S_LOAD  = 8'b0010_0000,
    S_MDU   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  // A register index is usable when it is neither register zero nor
  // beyond the implemented file.
  function automatic logic idx_ok(input logic [IW-1:0] idx);
    return (idx != '0) && ((IW + 1)'(idx) < (IW + 1)'(REG_COUNT));
  endfunction

  // A register that has never been written since reset reads as zero.
  function automatic logic [XL-1:0] rf_mask(input logic [IW-1:0]        idx,
                                            input logic [XL-1:0]        data,
                                            input logic [REG_COUNT-1:0] vld);
    logic hit;
    hit = idx_ok(idx) ? vld[idx[RA_W-1:0]] : 1'b0;
    return hit ? data : '0;
  endfunction

  state_t                 state_r, state_nxt;
  logic [MA_W-1:0]        clr_r, clr_nxt;
  logic [PW-1:0]          pc_r, pc_nxt;
  logic                   halt_r, halt_nxt;
  logic [REG_COUNT-1:0]   rf_valid_r;
  logic                   out_valid_r;
  logic                   out_load;
  sic_pkg::in_t           ins_r, ins_nxt;
  logic [XL-1:0]          a_r, a_nxt;
  logic [XL-1:0]          b_r, b_nxt;
  sic_pkg::out_t          res_r, res_nxt;
  sic_pkg::out_t          out_data_r;

  logic                   rf_we;
  logic [XL-1:0]          rf_wdata;
  logic [IW-1:0]          rf_ridx;
  logic [XL-1:0]          rf_rdata;
  logic [IW-1:0]          rf_tag;
  logic [XL-1:0]          rf_val;

  logic                   mem_we;
  logic [MA_W-1:0]        mem_waddr;
  logic [XL-1:0]          mem_wdata;
  logic [MA_W-1:0]        mem_raddr;
  logic [XL-1:0]          mem_rdata;

  logic [XL-1:0]          simm;
  logic [XL-1:0]          alu_y;
  logic                   alu_sub;
  logic [XL:0]            alu_res;
  logic                   cmp_eq;
  logic                   cmp_lt;
  logic                   addr_bad;
  logic                   dest_ok;
  logic [PW-1:0]          pc_inc;
  logic                   wr_req;
  logic [XL-1:0]          wr_val;

  sic_pkg::mdu_req_t      mdu_req;
  sic_pkg::mdu_rsp_t      mdu_rsp;

  // Register file: written from the sequencer, read one operand per cycle.
  sic_ram #(
    .WIDTH (XL),
    .DEPTH (REG_COUNT)
  ) u_rf (
    .clk   (clk),
    .we    (rf_we),
    .waddr (ins_r.dest_reg[RA_W-1:0]),
    .wdata (rf_wdata),
    .raddr (rf_ridx[RA_W-1:0]),
    .rdata (rf_rdata)
  );

  // Data memory, cleared by a sweep after reset.
  sic_ram #(
    .WIDTH (XL),
    .DEPTH (MEM_WORDS)
  ) u_dmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sic_alu u_alu (
    .x   (a_r),
    .y   (alu_y),
    .sub (alu_sub),
    .res (alu_res)
  );

  sic_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mdu_req),
    .opa   (a_r),
    .opb   (b_r),
    .rsp   (mdu_rsp)
  );

  assign simm    = {{(XL - sic_pkg::IMM_W){ins_r.immediate[sic_pkg::IMM_W-1]}},
                    ins_r.immediate};
  assign pc_inc  = pc_r + PW'(1);
  assign dest_ok = idx_ok(ins_r.dest_reg);

  // Immediate forms use the sign-extended immediate as the second operand;
  // branches subtract and look at the sign and zero of the difference.
  always_comb begin
    alu_y = b_r;
    if ((ins_r.mode == sic_pkg::MODE_ADDI) || (ins_r.mode == sic_pkg::MODE_SUBI) ||
        (ins_r.mode == sic_pkg::MODE_LW)   || (ins_r.mode == sic_pkg::MODE_SW)) begin
      alu_y = simm;
    end
  end

  assign alu_sub = (ins_r.mode == sic_pkg::MODE_SUBI) || (ins_r.mode == sic_pkg::MODE_SUB) ||
                   (ins_r.mode == sic_pkg::MODE_BEQ)  || (ins_r.mode == sic_pkg::MODE_BNE) ||
                   (ins_r.mode == sic_pkg::MODE_BGT)  || (ins_r.mode == sic_pkg::MODE_BLT);

  assign cmp_eq   = (alu_res == '0);
  assign cmp_lt   = alu_res[XL];
  // The address is the exact signed sum, so any wrap shows as out of range.
  assign addr_bad = alu_res[XL] || (alu_res >= MEM_LIM);

  // Register index whose value arrives on the read port this cycle.
  always_comb begin
    rf_tag = ins_r.dest_reg;
    if (state_r == S_RB) begin
      rf_tag = ins_r.src_reg_a;
    end else if (state_r == S_RD) begin
      rf_tag = ins_r.src_reg_b;
    end
  end

  assign rf_val = rf_mask(rf_tag, rf_rdata, rf_valid_r);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    pc_nxt    = pc_r;
    halt_nxt  = halt_r;
    ins_nxt   = ins_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    res_nxt   = res_r;
    out_load  = 1'b0;
    rf_ridx   = ins_r.dest_reg;
    mem_we    = 1'b0;
    mem_waddr = alu_res[MA_W-1:0];
    mem_wdata = rf_val;
    mem_raddr = alu_res[MA_W-1:0];
    mdu_req   = '0;
    wr_req    = 1'b0;
    wr_val    = '0;
    rf_we     = 1'b0;
    rf_wdata  = '0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + MA_W'(1);
        if (clr_r == MA_W'(MEM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        // Start reading the first operand as the request arrives.
        rf_ridx = in_data.src_reg_a;
        if (in_valid) begin
          ins_nxt = in_data;
          if (halt_r) begin
            res_nxt.next_pc     = pc_r;
            res_nxt.write_value = '0;
            res_nxt.halted      = 1'b1;
            res_nxt.fault       = sic_pkg::FAULT_NONE;
            state_nxt           = S_OUT;
          end else begin
            state_nxt = S_RB;
          end
        end
      end
      S_RB: begin
        a_nxt     = rf_val;
        rf_ridx   = ins_r.src_reg_b;
        state_nxt = S_RD;
      end
      S_RD: begin
        b_nxt     = rf_val;
        rf_ridx   = ins_r.dest_reg;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        pc_nxt              = pc_inc;
        res_nxt.write_value = '0;
        res_nxt.halted      = 1'b0;
        res_nxt.fault       = sic_pkg::FAULT_NONE;
        state_nxt           = S_OUT;
        unique case (ins_r.mode)
          sic_pkg::MODE_ADDI, sic_pkg::MODE_SUBI,
          sic_pkg::MODE_ADD,  sic_pkg::MODE_SUB: begin
            wr_req = 1'b1;
            wr_val = alu_res[XL-1:0];
          end
          sic_pkg::MODE_MOV: begin
            wr_req = 1'b1;
            wr_val = a_r;
          end
          sic_pkg::MODE_LI: begin
            wr_req = 1'b1;
            wr_val = simm;
          end
          sic_pkg::MODE_LW: begin
            if (addr_bad) begin
              res_nxt.fault = sic_pkg::FAULT_ADDR;
            end else begin
              state_nxt = S_LOAD;
            end
          end
          sic_pkg::MODE_SW: begin
            if (addr_bad) begin
              res_nxt.fault = sic_pkg::FAULT_ADDR;
            end else begin
              mem_we              = 1'b1;
              res_nxt.write_value = rf_val;
            end
          end
          sic_pkg::MODE_BEQ: begin
            if (cmp_eq) begin
              pc_nxt = ins_r.jump_target;
            end
          end
          sic_pkg::MODE_BNE: begin
            if (!cmp_eq) begin
              pc_nxt = ins_r.jump_target;
            end
          end
          sic_pkg::MODE_BGT: begin
            if (!cmp_lt && !cmp_eq) begin
              pc_nxt = ins_r.jump_target;
            end
          end
          sic_pkg::MODE_BLT: begin
            if (cmp_lt) begin
              pc_nxt = ins_r.jump_target;
            end
          end
          sic_pkg::MODE_J: begin
            pc_nxt = ins_r.jump_target;
          end
          sic_pkg::MODE_MUL: begin
            mdu_req.start = 1'b1;
            state_nxt     = S_MDU;
          end
          sic_pkg::MODE_DIV: begin
            if (b_r == '0) begin
              // Division by zero still clears the destination.
              wr_req              = 1'b1;
              wr_val              = '0;
              res_nxt.fault       = sic_pkg::FAULT_DIV0;
            end else begin
              mdu_req.start  = 1'b1;
              mdu_req.is_div = 1'b1;
              state_nxt      = S_MDU;
            end
          end
          sic_pkg::MODE_HALT: begin
            halt_nxt       = 1'b1;
            res_nxt.halted = 1'b1;
          end
        endcase
        res_nxt.next_pc = pc_nxt;
      end
      S_LOAD: begin
        wr_req    = 1'b1;
        wr_val    = mem_rdata;
        state_nxt = S_OUT;
      end
      S_MDU: begin
        if (mdu_rsp.done) begin
          wr_req    = 1'b1;
          wr_val    = mdu_rsp.result;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    // A discarded register write reports zero.
    if (wr_req) begin
      rf_we               = dest_ok;
      rf_wdata            = wr_val;
      res_nxt.write_value = dest_ok ? wr_val : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pc_r        <= '0;
      halt_r      <= 1'b0;
      rf_valid_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pc_r    <= pc_nxt;
      halt_r  <= halt_nxt;
      if (rf_we) begin
        rf_valid_r[ins_r.dest_reg[RA_W-1:0]] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ins_r <= ins_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_data_r <= res_r;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Once halted, the core stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag dropped without reset");

  // While halted the program counter does not move.
  a_halt_pc: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> $stable(pc_r))
    else $error("program counter moved while halted");

  // Register zero is never written.
  a_rf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> (ins_r.dest_reg != '0))
    else $error("write to register zero");

  // The multiply/divide unit only finishes while the sequencer waits for it.
  a_mdu_done: assert property (@(posedge clk) disable iff (!rst_n)
    mdu_rsp.done |-> (state_r == S_MDU))
    else $error("multiply/divide result with no waiting request");

endmodule

// File: verif/scalar_integer_core_step_tb.sv
// Self-checking testbench for the scalar integer core, with a shadow copy of its state.
`timescale 1ns / 100ps

module scalar_integer_core_step_tb;

  localparam int XLEN          = sic_pkg::XLEN;
  localparam int PC_W          = sic_pkg::PC_W;
  localparam int REG_IDX_W     = sic_pkg::REG_IDX_W;
  localparam int IMM_W         = sic_pkg::IMM_W;
  localparam int MEM_WORDS_DEF = sic_pkg::MEM_WORDS_DEF;
  localparam int REG_COUNT_DEF = sic_pkg::REG_COUNT_DEF;

  // The scoreboard keeps its own register file, data memory, program counter
  // and halt flag. Each accepted request is executed against that copy, and
  // the outcome waits in a queue until the core hands back its result.
  class core_scoreboard;
    logic [XLEN-1:0] regs [REG_COUNT_DEF];
    logic [XLEN-1:0] mem [MEM_WORDS_DEF];
    logic [PC_W-1:0] pc;
    bit              halted;
    sic_pkg::out_t   pending_results[$];
    int              errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      pc = '0;
      halted = 1'b0;
      errors = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Register zero, and any index past the end of the file, reads as zero.
    function logic [XLEN-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
      if (idx == 0 || idx >= REG_COUNT_DEF) return '0;
      return regs[idx];
    endfunction

    // Writes to register zero are dropped, and then nothing counts as written.
    function logic [XLEN-1:0] reg_write(logic [REG_IDX_W-1:0] idx, logic [XLEN-1:0] v);
      if (idx == 0 || idx >= REG_COUNT_DEF) return '0;
      regs[idx] = v;
      return v;
    endfunction

    function void accept_instr(sic_pkg::in_t instr);
      sic_pkg::out_t   res;
      logic [XLEN-1:0] a;
      logic [XLEN-1:0] b;
      logic [XLEN-1:0] simm;
      logic [XLEN-1:0] wv;
      logic [XLEN-1:0] ma;
      logic [XLEN-1:0] mb;
      logic [XLEN-1:0] quot;
      logic [PC_W-1:0] nxt;
      longint          addr;
      sic_pkg::fault_t flt;

      // Once halted, every request is answered with the held state.
      if (halted) begin
        res.next_pc = pc;
        res.write_value = '0;
        res.halted = 1'b1;
        res.fault = sic_pkg::FAULT_NONE;
        pending_results.push_back(res);
        return;
      end

      a = reg_value(instr.src_reg_a);
      b = reg_value(instr.src_reg_b);
      simm = {{(XLEN-IMM_W){instr.immediate[IMM_W-1]}}, instr.immediate};
      nxt = pc + PC_W'(1);
      wv = '0;
      flt = sic_pkg::FAULT_NONE;
      addr = longint'($signed(a)) + longint'($signed(simm));

      case (instr.mode)
        sic_pkg::MODE_ADDI: wv = reg_write(instr.dest_reg, a + simm);
        sic_pkg::MODE_SUBI: wv = reg_write(instr.dest_reg, a - simm);
        sic_pkg::MODE_LW, sic_pkg::MODE_SW: begin
          if (addr < 0 || addr >= MEM_WORDS_DEF) begin
            flt = sic_pkg::FAULT_ADDR;
          end else if (instr.mode == sic_pkg::MODE_LW) begin
            wv = reg_write(instr.dest_reg, mem[addr]);
          end else begin
            wv = reg_value(instr.dest_reg);
            mem[addr] = wv;
          end
        end
        sic_pkg::MODE_BEQ: if (a == b) nxt = instr.jump_target;
        sic_pkg::MODE_BNE: if (a != b) nxt = instr.jump_target;
        sic_pkg::MODE_BGT: if ($signed(a) > $signed(b)) nxt = instr.jump_target;
        sic_pkg::MODE_BLT: if ($signed(a) < $signed(b)) nxt = instr.jump_target;
        sic_pkg::MODE_J:   nxt = instr.jump_target;
        sic_pkg::MODE_MOV: wv = reg_write(instr.dest_reg, a);
        sic_pkg::MODE_LI:  wv = reg_write(instr.dest_reg, simm);
        sic_pkg::MODE_ADD: wv = reg_write(instr.dest_reg, a + b);
        sic_pkg::MODE_SUB: wv = reg_write(instr.dest_reg, a - b);
        sic_pkg::MODE_MUL: wv = reg_write(instr.dest_reg, a * b);
        sic_pkg::MODE_DIV: begin
          if (b == 0) begin
            void'(reg_write(instr.dest_reg, '0));
            flt = sic_pkg::FAULT_DIV0;
          end else begin
            // Divide the magnitudes, then restore the sign; this truncates
            // toward zero and lets the most negative value over -1 wrap.
            ma = a[XLEN-1] ? ('0 - a) : a;
            mb = b[XLEN-1] ? ('0 - b) : b;
            quot = ma / mb;
            wv = reg_write(instr.dest_reg, (a[XLEN-1] ^ b[XLEN-1]) ? ('0 - quot) : quot);
          end
        end
        default: halted = 1'b1;
      endcase

      pc = nxt;
      res.next_pc = pc;
      res.write_value = wv;
      res.halted = halted;
      res.fault = flt;
      pending_results.push_back(res);
    endfunction

    task report(string what, logic [XLEN-1:0] got, logic [XLEN-1:0] want);
      errors++;
      $display("%0t: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task check_result(sic_pkg::out_t got);
      sic_pkg::out_t want;
      if (pending_results.size() == 0) begin
        report("result with nothing outstanding", XLEN'(got.next_pc), '0);
        return;
      end
      want = pending_results.pop_front();
      if (got.next_pc !== want.next_pc)
        report("next_pc", XLEN'(got.next_pc), XLEN'(want.next_pc));
      if (got.write_value !== want.write_value)
        report("write_value", got.write_value, want.write_value);
      if (got.halted !== want.halted)
        report("halted", XLEN'(got.halted), XLEN'(want.halted));
      if (got.fault !== want.fault)
        report("fault", XLEN'(got.fault), XLEN'(want.fault));
    endtask
  endclass

  // Every input starts from a known value at time zero.
  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  sic_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  sic_pkg::out_t out_data;

  // While steady is set neither side inserts idle cycles.
  bit steady = 1'b0;

  core_scoreboard sb = new();

  always #6 clk = ~clk;

  scalar_integer_core_step dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The receiver stalls at random, roughly 23 percent of the time. Its ready
  // changes on the falling edge, well away from the sampling edge.
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 23);
  end

  // Results are taken at the rising edge on which they are handed over.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  function automatic sic_pkg::in_t mk_instr(sic_pkg::mode_t m, logic [REG_IDX_W-1:0] rd,
                                            logic [REG_IDX_W-1:0] ra,
                                            logic [REG_IDX_W-1:0] rb,
                                            logic [IMM_W-1:0] imm, logic [PC_W-1:0] tgt);
    sic_pkg::in_t r;
    r.mode = m;
    r.dest_reg = rd;
    r.src_reg_a = ra;
    r.src_reg_b = rb;
    r.immediate = imm;
    r.jump_target = tgt;
    return r;
  endfunction

  // Random request with the halt excluded, since a halt ends all useful work.
  // Loads and stores are weighted up and mostly steered onto addresses near
  // the ends of the memory, or into a small window so that loads find data
  // that earlier stores left behind. The base register's current value is
  // taken from the scoreboard, which is up to date with every earlier request.
  function automatic sic_pkg::in_t random_instr();
    sic_pkg::in_t r;
    int           pick;
    longint       want;
    longint       base;
    longint       off;

    pick = $urandom_range(0, 19);
    if (pick <= int'(sic_pkg::MODE_DIV)) r.mode = sic_pkg::mode_t'(pick);
    else r.mode = (pick % 2) ? sic_pkg::MODE_SW : sic_pkg::MODE_LW;
    r.dest_reg = ($urandom_range(0, 7) == 0) ? '0 : $urandom_range(1, 31);
    r.src_reg_a = $urandom_range(0, 31);
    r.src_reg_b = $urandom_range(0, 31);

    case ($urandom_range(0, 3))
      1: r.immediate = $urandom_range(0, 16) - 8;
      2: r.immediate = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: r.immediate = $urandom;
    endcase

    case ($urandom_range(0, 7))
      0: r.jump_target = sb.pc;
      1: r.jump_target = '1;
      default: r.jump_target = $urandom;
    endcase

    if ((r.mode == sic_pkg::MODE_BEQ || r.mode == sic_pkg::MODE_BNE ||
         r.mode == sic_pkg::MODE_BGT || r.mode == sic_pkg::MODE_BLT) &&
        $urandom_range(0, 3) == 0)
      r.src_reg_b = r.src_reg_a;
    if (r.mode == sic_pkg::MODE_DIV && $urandom_range(0, 5) == 0) r.src_reg_b = '0;

    if ((r.mode == sic_pkg::MODE_LW || r.mode == sic_pkg::MODE_SW) &&
        $urandom_range(0, 9) != 0) begin
      case ($urandom_range(0, 8))
        0, 1, 2, 3, 4: want = $urandom_range(0, 31);
        5, 6: want = $urandom_range(0, MEM_WORDS_DEF - 1);
        7: want = $urandom_range(MEM_WORDS_DEF - 4, MEM_WORDS_DEF + 3);
        default: want = longint'($urandom_range(0, 7)) - 4;
      endcase
      base = (r.src_reg_a == 0) ? 0 : $signed(sb.regs[r.src_reg_a]);
      off = want - base;
      if (off >= -32768 && off <= 32767) begin
        r.immediate = off;
      end else begin
        r.src_reg_a = '0;
        r.immediate = want;
      end
    end
    return r;
  endfunction

  // Offers one request from a falling edge, perhaps after some idle cycles,
  // and holds it until the core accepts it. Valid stays high afterwards; the
  // next call either lowers it while it idles or puts the next request up.
  task automatic send_instr(input sic_pkg::in_t instr);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 23) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_data = instr;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.accept_instr(instr);
  endtask

  // Stops sending until every outstanding result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int n;

    // Reset is held from time zero. The core then clears its data memory,
    // during which in_ready stays low and the first request simply waits.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: field extremes, every operation but halt and the corner cases.
    send_instr(mk_instr(sic_pkg::MODE_LI,   5'd1,  5'd0,  5'd0, 16'sh7FFF, '0));
    send_instr(mk_instr(sic_pkg::MODE_LI,   5'd2,  5'd0,  5'd0, 16'sh8000, '0));
    // r6 = 2^30, then 2^31, the most negative word.
    send_instr(mk_instr(sic_pkg::MODE_MUL,  5'd6,  5'd2,  5'd2, '0, '0));
    send_instr(mk_instr(sic_pkg::MODE_ADD,  5'd6,  5'd6,  5'd6, '0, '0));
    send_instr(mk_instr(sic_pkg::MODE_LI,   5'd7,  5'd0,  5'd0, 16'hFFFF, '0));
    // Most negative value divided by minus one wraps back onto itself.
    send_instr(mk_instr(sic_pkg::MODE_DIV,  5'd8,  5'd6,  5'd7, '0, '0));
    // Division by zero clears the destination and flags the fault.
    send_instr(mk_instr(sic_pkg::MODE_DIV,  5'd1,  5'd1,  5'd0, '0, '0));
    send_instr(mk_instr(sic_pkg::MODE_LI,   5'd1,  5'd0,  5'd0, 16'sh7FFF, '0));
    // A negative quotient truncates toward zero.
    send_instr(mk_instr(sic_pkg::MODE_DIV,  5'd10, 5'd2,  5'd1, '0, '0));
    // A write to register zero is dropped.
    send_instr(mk_instr(sic_pkg::MODE_ADDI, 5'd0,  5'd1,  5'd0, 16'd5, '0));
    // Subtraction wraps from the most negative to the most positive word.
    send_instr(mk_instr(sic_pkg::MODE_SUBI, 5'd11, 5'd6,  5'd0, 16'd1, '0));
    // Stores at both ends of memory, a load at the top end, and accesses just outside both ends.
    send_instr(mk_instr(sic_pkg::MODE_SW,   5'd1,  5'd0,  5'd0, 16'd0, '0));
    send_instr(mk_instr(sic_pkg::MODE_SW,   5'd2,  5'd0,  5'd0, MEM_WORDS_DEF - 1, '0));
    send_instr(mk_instr(sic_pkg::MODE_LW,   5'd12, 5'd0,  5'd0, MEM_WORDS_DEF - 1, '0));
    send_instr(mk_instr(sic_pkg::MODE_LW,   5'd13, 5'd0,  5'd0, MEM_WORDS_DEF, '0));
    send_instr(mk_instr(sic_pkg::MODE_SW,   5'd1,  5'd0,  5'd0, 16'hFFFF, '0));
    send_instr(mk_instr(sic_pkg::MODE_MOV,  5'd14, 5'd11, 5'd0, '0, '0));
    send_instr(mk_instr(sic_pkg::MODE_SUB,  5'd15, 5'd6,  5'd7, '0, '0));
    // Branches, where signed and unsigned comparison would disagree.
    send_instr(mk_instr(sic_pkg::MODE_BEQ,  5'd0,  5'd1,  5'd1, '0, $urandom));
    send_instr(mk_instr(sic_pkg::MODE_BNE,  5'd0,  5'd1,  5'd2, '0, $urandom));
    send_instr(mk_instr(sic_pkg::MODE_BGT,  5'd0,  5'd1,  5'd2, '0, $urandom));
    send_instr(mk_instr(sic_pkg::MODE_BLT,  5'd0,  5'd6,  5'd1, '0, $urandom));
    // Jump to the last address, so that the next request wraps the counter.
    send_instr(mk_instr(sic_pkg::MODE_J,    5'd0,  5'd0,  5'd0, '0, '1));
    send_instr(mk_instr(sic_pkg::MODE_ADDI, 5'd16, 5'd0,  5'd0, '0, '0));
    // A jump onto its own address must stay there.
    send_instr(mk_instr(sic_pkg::MODE_J,    5'd0,  5'd0,  5'd0, '0, sb.pc));

    drain_results();

    // Random part, with a long stretch in the middle free of idle cycles and
    // one more pause in which the sender waits for the core to empty.
    for (n = 0; n < 1410; n++) begin
      steady = (n >= 500 && n < 800);
      if (n == 700) drain_results();
      send_instr(random_instr());
    end
    steady = 1'b0;

    // Halt, then requests that the halted core must ignore, with halts among them.
    send_instr(mk_instr(sic_pkg::MODE_HALT, 5'd3, 5'd4, 5'd5, '0, '0));
    for (n = 0; n < 15; n++)
      send_instr((n % 4 == 3) ? mk_instr(sic_pkg::MODE_HALT, '0, '0, '0, '0, '0)
                              : random_instr());

    drain_results();
    // Give a stray extra result time to show itself.
    repeat (50) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** scalar_integer_core_step: PASSED **");
    end else begin
      $display("** scalar_integer_core_step: FAILED **");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #10_000_000;
    $display("** scalar_integer_core_step: FAILED **");
    $finish;
  end

endmodule
